/* hw/rtl/bbmt_pkg.sv */
// ----------------------------------------------------------------------------
// bbmt_pkg
// Shared types, codes and constants of the burst bus memory target.
// ----------------------------------------------------------------------------
package bbmt_pkg;

	localparam int HALF_W       = 16;
	localparam int POS_W        = 4;
	localparam int DIVIDEND_W   = 20;
	localparam int SCRATCH_OP_W = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	localparam logic [31:0] MAIN_LIMIT    = 32'h00FF_FFFF;
	localparam logic [7:0]  IO_PAGE       = 8'hFE;

	localparam logic [CFG_DATA_W-1:0] CPU_CLOCK_RESET = 32'd12_000_000;
	localparam logic [CFG_DATA_W-1:0] BUS_CLOCK_RESET = 32'd6_000_000;

	localparam logic [CFG_IDX_W-1:0] CFG_CPU_CLOCK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUS_CLOCK = 2'd1;

	localparam logic REQ_OPEN = 1'b0;

	typedef enum logic [1:0] {
		RGN_MAIN     = 2'd0,
		RGN_CLOCK    = 2'd1,
		RGN_SCRATCH  = 2'd2,
		RGN_UNMAPPED = 2'd3
	} region_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_EXEC,
		ST_RMW
	} state_t;

	function automatic logic [HALF_W-1:0] merge_bytes(
		input logic [HALF_W-1:0] old_val,
		input logic [HALF_W-1:0] new_val,
		input logic              en_lo,
		input logic              en_hi
	);
		logic [HALF_W-1:0] v;
		v = old_val;
		if (en_lo) begin
			v[7:0] = new_val[7:0];
		end
		if (en_hi) begin
			v[15:8] = new_val[15:8];
		end
		return v;
	endfunction

endpackage

/* hw/rtl/bbmt_ram.sv */
// ----------------------------------------------------------------------------
// bbmt_ram
// Single-clock halfword memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bbmt_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [bbmt_pkg::HALF_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [bbmt_pkg::HALF_W-1:0] rdata
);
	import bbmt_pkg::*;

	logic [HALF_W-1:0] mem [DEPTH];
	logic [HALF_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/bbmt_cell_mod.sv */
// ----------------------------------------------------------------------------
// bbmt_cell_mod
// Reciprocal remainder unit: folds a cell number into the cell count by a
// multiply with a fixed reciprocal, a subtract of the quotient multiple and
// one final correction. Start passes through go_q, vld_s1 and vld_s2 to done.
// ----------------------------------------------------------------------------
module bbmt_cell_mod #(
	parameter int MAIN_CELLS    = 4096,
	parameter int SCRATCH_CELLS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            scratch,
	input  logic [bbmt_pkg::DIVIDEND_W-1:0] dividend,
	output logic                            done,
	output logic [bbmt_pkg::DIVIDEND_W-1:0] remainder
);
	import bbmt_pkg::*;

	localparam int DIV_W   = DIVIDEND_W + 1;
	localparam int RECIP_W = DIVIDEND_W + 2;
	localparam int PROD_W  = DIVIDEND_W + RECIP_W;
	localparam int K_MAIN  = DIVIDEND_W + $clog2(MAIN_CELLS);
	localparam int K_SCR   = DIVIDEND_W + $clog2(SCRATCH_CELLS);
	localparam longint unsigned M_MAIN_L = (64'd1 << K_MAIN) / 64'(MAIN_CELLS);
	localparam longint unsigned M_SCR_L  = (64'd1 << K_SCR) / 64'(SCRATCH_CELLS);
	localparam logic [RECIP_W-1:0] M_MAIN = RECIP_W'(M_MAIN_L);
	localparam logic [RECIP_W-1:0] M_SCR  = RECIP_W'(M_SCR_L);
	localparam logic [DIV_W-1:0]   N_MAIN = DIV_W'(MAIN_CELLS);
	localparam logic [DIV_W-1:0]   N_SCR  = DIV_W'(SCRATCH_CELLS);

	logic [DIVIDEND_W-1:0] x_q;
	logic                  sel_q;
	logic                  go_q;
	logic [DIVIDEND_W-1:0] q_s1;
	logic                  vld_s1;
	logic [DIV_W-1:0]      r_s2;
	logic                  vld_s2;

	logic [RECIP_W-1:0]    recip;
	logic [DIV_W-1:0]      modulus;
	logic [PROD_W-1:0]     prod;
	logic [PROD_W-1:0]     quot_full;
	logic [DIV_W-1:0]      quot_mul;
	logic [DIV_W-1:0]      r_fix;

	assign recip     = sel_q ? M_SCR : M_MAIN;
	assign modulus   = sel_q ? N_SCR : N_MAIN;
	// quotient estimate is exact or one low
	assign prod      = {{RECIP_W{1'b0}}, x_q} * {{DIVIDEND_W{1'b0}}, recip};
	assign quot_full = sel_q ? (prod >> K_SCR) : (prod >> K_MAIN);
	assign quot_mul  = {1'b0, q_s1} * modulus;
	assign r_fix     = (r_s2 >= modulus) ? (r_s2 - modulus) : r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q   <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			go_q   <= start;
			vld_s1 <= go_q;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= dividend;
			sel_q <= scratch;
		end
		if (go_q) begin
			q_s1 <= quot_full[DIVIDEND_W-1:0];
		end
		if (vld_s1) begin
			r_s2 <= {1'b0, x_q} - quot_mul;
		end
	end

	assign done      = vld_s2;
	assign remainder = r_fix[DIVIDEND_W-1:0];

endmodule

/* hw/rtl/burst_bus_memory_target_unit.sv */
// Result path: an accepted beat goes through ST_EXEC or ST_RMW to the output
// register; an opening beat to main or scratch memory first passes ST_MOD
// (cell remainder) and ST_EXEC (store read). In a burst each beat takes a store
// read, then result and write-back; s_tready is low until its result is pushed.
// Reset: both stores are swept to zero over max(MAIN_CELLS, SCRATCH_CELLS) * 8
// addresses with s_tready low.
// ----------------------------------------------------------------------------
// burst_bus_memory_target_unit
// Burst bus target: address decode, clock constants, main and scratch stores.
// ----------------------------------------------------------------------------
module burst_bus_memory_target_unit #(
	parameter int MAIN_CELLS    = 4096,
	parameter int SCRATCH_CELLS = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [31:0] address, [47:32] write_data, [48] enable_low_byte,
	// [49] enable_high_byte, [55:50] zero
	input  logic [55:0]                     s_tdata,
	// [0] req_type, [1] is_write
	input  logic [1:0]                      s_tuser,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] read_data
	output logic [15:0]                     m_tdata,
	// [1:0] region, [2] past_cell_end
	output logic [2:0]                      m_tuser,
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bbmt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbmt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bbmt_pkg::*;

	localparam int CW         = $clog2(MAIN_CELLS);
	localparam int SCW        = $clog2(SCRATCH_CELLS);
	localparam int CELL_W     = (CW > SCW) ? CW : SCW;
	localparam int MAW        = CW + 3;
	localparam int SAW        = SCW + 3;
	localparam int MAIN_DEPTH = MAIN_CELLS * 8;
	localparam int SCR_DEPTH  = SCRATCH_CELLS * 8;
	localparam int CLR_DEPTH  = (MAIN_DEPTH > SCR_DEPTH) ? MAIN_DEPTH : SCR_DEPTH;
	localparam int CLR_W      = $clog2(CLR_DEPTH);
	localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] cpu_clock_hz_q;
	logic [CFG_DATA_W-1:0] bus_clock_hz_q;

	region_t           region_q;
	logic [CELL_W-1:0] cell_q;
	logic [POS_W-1:0]  pos_q;
	logic              wr_q;
	logic [HALF_W-1:0] data_q;
	logic              en_lo_q;
	logic              en_hi_q;
	logic              last_q;
	logic [CLR_W-1:0]  clr_q;

	logic              out_valid_q;
	logic [HALF_W-1:0] out_data_q;
	logic [2:0]        out_user_q;
	logic              out_last_q;

	logic [31:0]       in_addr;
	logic              accept;
	logic              out_free;
	logic              mem_access;
	logic              push;

	region_t               dec_region;
	logic [POS_W-1:0]      dec_pos;
	logic [DIVIDEND_W-1:0] dec_op;
	logic                  dec_mem;

	logic                  mod_start;
	logic                  mod_done;
	logic [DIVIDEND_W-1:0] mod_rem;

	logic              ram_re;
	logic              main_we;
	logic              scr_we;
	logic [MAW-1:0]    main_addr;
	logic [SAW-1:0]    scr_addr;
	logic [MAW-1:0]    main_waddr;
	logic [SAW-1:0]    scr_waddr;
	logic [HALF_W-1:0] mem_wdata;
	logic [HALF_W-1:0] main_rdata;
	logic [HALF_W-1:0] scr_rdata;
	logic [HALF_W-1:0] old_half;
	logic [HALF_W-1:0] merged;
	logic [HALF_W-1:0] clock_half;
	logic [HALF_W-1:0] rd_val;
	logic              past_val;

	assign in_addr   = s_tdata[31:0];
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign mem_access = ((region_q == RGN_MAIN) || (region_q == RGN_SCRATCH)) && !pos_q[3];

	// Address decode of an opening beat
	always_comb begin
		dec_region = RGN_UNMAPPED;
		dec_pos    = '0;
		dec_op     = '0;
		priority if (in_addr <= MAIN_LIMIT) begin
			dec_region = RGN_MAIN;
			dec_op     = in_addr[23:4];
			dec_pos    = {1'b0, in_addr[3:1]};
		end else if (in_addr[31:24] == IO_PAGE) begin
			priority if (in_addr[23:3] == '0) begin
				dec_region = RGN_CLOCK;
				dec_pos    = {2'b00, in_addr[2:1]};
			end else if ((in_addr[23:12] == '0) && in_addr[11]) begin
				dec_region = RGN_SCRATCH;
				dec_op     = {{(DIVIDEND_W - SCRATCH_OP_W){1'b0}}, in_addr[10:4]};
				dec_pos    = {1'b0, in_addr[3:1]};
			end else begin
				dec_region = RGN_UNMAPPED;
			end
		end else begin
			dec_region = RGN_UNMAPPED;
		end
	end

	assign dec_mem = (dec_region == RGN_MAIN) || (dec_region == RGN_SCRATCH);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser[0] == REQ_OPEN) begin
						state_d = dec_mem ? ST_MOD : ST_EXEC;
					end else begin
						state_d = mem_access ? ST_RMW : ST_EXEC;
					end
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (mem_access) begin
					state_d = ST_RMW;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_RMW: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		mod_start = 1'b0;
		push      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				// keep a read of the current halfword in flight for continuation beats
				ram_re    = 1'b1;
				mod_start = accept && (s_tuser[0] == REQ_OPEN) && dec_mem;
			end
			ST_MOD: begin
			end
			ST_EXEC: begin
				ram_re = mem_access;
				push   = !mem_access && out_free;
			end
			ST_RMW: begin
				push = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	bbmt_cell_mod #(
		.MAIN_CELLS   (MAIN_CELLS),
		.SCRATCH_CELLS(SCRATCH_CELLS)
	) u_cell_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.scratch  (dec_region == RGN_SCRATCH),
		.dividend (dec_op),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	// Store access
	assign main_addr = {cell_q[CW-1:0], pos_q[2:0]};
	assign scr_addr  = {cell_q[SCW-1:0], pos_q[2:0]};
	assign old_half  = (region_q == RGN_SCRATCH) ? scr_rdata : main_rdata;
	assign merged    = merge_bytes(old_half, data_q, en_lo_q, en_hi_q);

	always_comb begin
		main_we    = 1'b0;
		scr_we     = 1'b0;
		main_waddr = main_addr;
		scr_waddr  = scr_addr;
		mem_wdata  = merged;
		if (state_q == ST_CLEAR) begin
			main_we    = ({1'b0, clr_q} < (CLR_W + 1)'(MAIN_DEPTH));
			scr_we     = ({1'b0, clr_q} < (CLR_W + 1)'(SCR_DEPTH));
			main_waddr = clr_q[MAW-1:0];
			scr_waddr  = clr_q[SAW-1:0];
			mem_wdata  = '0;
		end else if ((state_q == ST_RMW) && push && wr_q) begin
			main_we = (region_q == RGN_MAIN);
			scr_we  = (region_q == RGN_SCRATCH);
		end
	end

	bbmt_ram #(
		.DEPTH(MAIN_DEPTH),
		.AW   (MAW)
	) u_main_ram (
		.clk  (clk),
		.we   (main_we),
		.waddr(main_waddr),
		.wdata(mem_wdata),
		.re   (ram_re),
		.raddr(main_addr),
		.rdata(main_rdata)
	);

	bbmt_ram #(
		.DEPTH(SCR_DEPTH),
		.AW   (SAW)
	) u_scratch_ram (
		.clk  (clk),
		.we   (scr_we),
		.waddr(scr_waddr),
		.wdata(mem_wdata),
		.re   (ram_re),
		.raddr(scr_addr),
		.rdata(scr_rdata)
	);

	// Result of the current beat
	always_comb begin
		unique case (pos_q[1:0])
			2'd0:    clock_half = cpu_clock_hz_q[15:0];
			2'd1:    clock_half = cpu_clock_hz_q[31:16];
			2'd2:    clock_half = bus_clock_hz_q[15:0];
			2'd3:    clock_half = bus_clock_hz_q[31:16];
			default: clock_half = '0;
		endcase
	end

	always_comb begin
		past_val = (region_q != RGN_UNMAPPED) && pos_q[3];
		rd_val   = '0;
		if (state_q == ST_RMW) begin
			rd_val = wr_q ? '0 : old_half;
		end else if ((region_q == RGN_CLOCK) && !wr_q && (pos_q[3:2] == 2'b00)) begin
			rd_val = clock_half;
		end
	end

	// Transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= RGN_UNMAPPED;
			cell_q   <= '0;
			pos_q    <= '0;
			wr_q     <= 1'b0;
			clr_q    <= '0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept && (s_tuser[0] == REQ_OPEN)) begin
				region_q <= dec_region;
				pos_q    <= dec_pos;
				wr_q     <= s_tuser[1];
				cell_q   <= '0;
			end
			if ((state_q == ST_MOD) && mod_done) begin
				cell_q <= mod_rem[CELL_W-1:0];
			end
			if (push) begin
				if ((region_q != RGN_UNMAPPED) && !pos_q[3]) begin
					pos_q <= pos_q + 1'b1;
				end
				if (last_q) begin
					region_q <= RGN_UNMAPPED;
				end
			end
		end
	end

	// Hold the beat payload
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q  <= s_tdata[47:32];
			en_lo_q <= s_tdata[48];
			en_hi_q <= s_tdata[49];
			last_q  <= s_tlast;
		end
	end

	// Clock constant registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_clock_hz_q <= CPU_CLOCK_RESET;
			bus_clock_hz_q <= BUS_CLOCK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_CPU_CLOCK) begin
				cpu_clock_hz_q <= cfg_data;
			end else if (cfg_index == CFG_BUS_CLOCK) begin
				bus_clock_hz_q <= cfg_data;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_data_q <= rd_val;
			out_user_q <= {past_val, region_q};
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

/* test/bus_target_mirror_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_target_mirror_pkg
// Beat and reply types and a mirror of the burst target. The mirror keeps its
// own copy of both stores, the open transaction and the clock words. It queues
// the reply each accepted beat should give and checks replies in order.
// ----------------------------------------------------------------------------
package bus_target_mirror_pkg;
	import bbmt_pkg::*;

	localparam logic [23:0] IO_CLOCK_END    = 24'h00_0007;
	localparam logic [23:0] IO_SCRATCH_BASE = 24'h00_0800;
	localparam logic [23:0] IO_SCRATCH_END  = 24'h00_0FFF;
	localparam logic [3:0]  CELL_HALVES     = 4'd8;
	localparam int          REPORT_CAP      = 30;

	typedef struct {
		logic        req_type;
		logic [31:0] address;
		logic        is_write;
		logic [15:0] write_data;
		logic        en_lo;
		logic        en_hi;
		logic        last;
	} beat_t;

	typedef struct {
		logic [15:0] read_data;
		region_t     region;
		logic        past_end;
		logic        last;
	} halfword_reply_t;

	class target_mirror #(int MAIN_N = 4096, int SCRATCH_N = 128);
		bit [15:0]       main_mem [MAIN_N*8];
		bit [15:0]       scratch_mem [SCRATCH_N*8];
		region_t         open_region;
		bit [19:0]       cell_idx;
		bit [3:0]        pos;
		bit              write_mode;
		bit [31:0]       cpu_hz;
		bit [31:0]       bus_hz;
		halfword_reply_t due [$];
		int unsigned     mismatches;
		int unsigned     checked;
		int unsigned     region_hits [4];
		int unsigned     past_hits;

		function new();
			open_region = RGN_UNMAPPED;
			cpu_hz      = CPU_CLOCK_RESET;
			bus_hz      = BUS_CLOCK_RESET;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_CPU_CLOCK) begin
				cpu_hz = val;
			end else if (idx == CFG_BUS_CLOCK) begin
				bus_hz = val;
			end
		endfunction

		function bit [15:0] blend(bit [15:0] old_half, bit [15:0] data, bit lo, bit hi);
			bit [15:0] v;
			v = old_half;
			if (lo) begin
				v[7:0] = data[7:0];
			end
			if (hi) begin
				v[15:8] = data[15:8];
			end
			return v;
		endfunction

		function void open_burst(logic [31:0] addr, logic wr);
			logic [23:0] io;
			io         = addr[23:0];
			write_mode = wr;
			cell_idx   = '0;
			pos        = '0;
			if (addr <= MAIN_LIMIT) begin
				open_region = RGN_MAIN;
				cell_idx    = 20'(addr[23:4] % MAIN_N);
				pos         = {1'b0, addr[3:1]};
			end else if (addr[31:24] == IO_PAGE && io <= IO_CLOCK_END) begin
				open_region = RGN_CLOCK;
				pos         = {2'b00, io[2:1]};
			end else if (addr[31:24] == IO_PAGE && io >= IO_SCRATCH_BASE
					&& io <= IO_SCRATCH_END) begin
				open_region = RGN_SCRATCH;
				cell_idx    = 20'(addr[10:4] % SCRATCH_N);
				pos         = {1'b0, addr[3:1]};
			end else begin
				open_region = RGN_UNMAPPED;
			end
		endfunction

		function void note_beat(beat_t b);
			halfword_reply_t r;
			int unsigned     slot;
			r.read_data = '0;
			r.past_end  = 1'b0;
			r.last      = b.last;
			if (b.req_type == REQ_OPEN) begin
				open_burst(b.address, b.is_write);
			end
			r.region = open_region;
			if (open_region != RGN_UNMAPPED) begin
				if (pos >= CELL_HALVES) begin
					r.past_end = 1'b1;
				end else begin
					case (open_region)
						RGN_MAIN: begin
							slot = (cell_idx % MAIN_N) * 8 + pos;
							if (write_mode) begin
								main_mem[slot] = blend(main_mem[slot], b.write_data,
									b.en_lo, b.en_hi);
							end else begin
								r.read_data = main_mem[slot];
							end
						end
						RGN_SCRATCH: begin
							slot = (cell_idx % SCRATCH_N) * 8 + pos;
							if (write_mode) begin
								scratch_mem[slot] = blend(scratch_mem[slot], b.write_data,
									b.en_lo, b.en_hi);
							end else begin
								r.read_data = scratch_mem[slot];
							end
						end
						default: begin
							// clock space is read only; halfwords 4..7 read zero
							if (!write_mode) begin
								case (pos)
									4'd0: r.read_data = cpu_hz[15:0];
									4'd1: r.read_data = cpu_hz[31:16];
									4'd2: r.read_data = bus_hz[15:0];
									4'd3: r.read_data = bus_hz[31:16];
									default: r.read_data = '0;
								endcase
							end
						end
					endcase
					pos++;
				end
			end
			region_hits[r.region]++;
			if (r.past_end) begin
				past_hits++;
			end
			due.push_back(r);
			if (b.last) begin
				open_region = RGN_UNMAPPED;
			end
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= REPORT_CAP) begin
				$display("mismatch at %0t, reply %0d: %s", $time, checked, what);
			end
		endfunction

		function void check_reply(logic [15:0] rd, logic [2:0] user, logic last);
			halfword_reply_t e;
			if (due.size() == 0) begin
				report("result item with no expectation pending");
				return;
			end
			e = due.pop_front();
			if (rd !== e.read_data) begin
				report($sformatf("read_data %h, want %h", rd, e.read_data));
			end
			if (user[1:0] !== e.region) begin
				report($sformatf("region %0d, want %0d", user[1:0], e.region));
			end
			if (user[2] !== e.past_end) begin
				report($sformatf("past_cell_end %b, want %b", user[2], e.past_end));
			end
			if (last !== e.last) begin
				report($sformatf("transaction_end %b, want %b", last, e.last));
			end
			checked++;
		endfunction

		function int unsigned pending();
			return due.size();
		endfunction
	endclass

endpackage

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives burst transactions into the bus target and checks every reply item
// against a mirror of its stores. A directed opening hits the address map
// edges, byte enables, clock words and cell overruns; random runs follow, each
// after new clock words, with random stalls on both sides or a long output hold.
// ----------------------------------------------------------------------------
module tb_top;
	import bbmt_pkg::*;
	import bus_target_mirror_pkg::*;

	localparam int MAIN_CELLS    = 4096;
	localparam int SCRATCH_CELLS = 128;
	localparam int CYCLE_LIMIT   = 400_000;
	localparam int RANDOM_ITEMS  = 1150;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 30;

	localparam logic                 REQ_MORE    = ~REQ_OPEN;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [55:0]           s_tdata   = '0;
	logic [1:0]            s_tuser   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [15:0]           m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned items_sent    = 0;
	int unsigned bursts_sent   = 0;
	int unsigned cycles        = 0;
	bit          hold_req      = 1'b0;

	target_mirror #(MAIN_CELLS, SCRATCH_CELLS) mirror;

	burst_bus_memory_target_unit #(
		.MAIN_CELLS    (MAIN_CELLS),
		.SCRATCH_CELLS (SCRATCH_CELLS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("[FAIL] regression broken");
		$finish;
	end

	// reply side: check the item taken at this edge, then pick next ready
	initial begin : reply_side
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				mirror.check_reply(m_tdata, m_tuser, m_tlast);
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_beat(input beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, b.en_hi, b.en_lo, b.write_data, b.address};
		s_tuser  <= {b.is_write, b.req_type};
		s_tlast  <= b.last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		mirror.note_beat(b);
		items_sent++;
	endtask

	task automatic send_fields(input logic rq, input logic [31:0] addr, input logic wr,
			input logic [15:0] data, input logic lo, input logic hi, input logic last);
		beat_t b;
		b.req_type   = rq;
		b.address    = addr;
		b.is_write   = wr;
		b.write_data = data;
		b.en_lo      = lo;
		b.en_hi      = hi;
		b.last       = last;
		send_beat(b);
	endtask

	function automatic beat_t random_beat();
		beat_t b;
		b.req_type   = REQ_MORE;
		b.address    = $urandom();
		b.is_write   = 1'($urandom_range(0, 1));
		b.write_data = 16'($urandom());
		b.en_lo      = 1'($urandom_range(0, 1));
		b.en_hi      = 1'($urandom_range(0, 1));
		b.last       = 1'b0;
		return b;
	endfunction

	task automatic send_random_burst();
		beat_t       b;
		int unsigned kind;
		int unsigned len;
		logic [31:0] addr;
		logic        wr;
		logic        close;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			// stray continuation beats outside a well-formed burst
			len = $urandom_range(1, 2);
			for (int i = 0; i < len; i++) begin
				b      = random_beat();
				b.last = 1'($urandom_range(0, 1));
				send_beat(b);
			end
		end else begin
			if (kind < 53) begin
				// mostly a few hot cells, aliased through the upper address bits
				if ($urandom_range(0, 9) < 7) begin
					addr = {8'h00, 8'($urandom()), 12'($urandom_range(0, 15)), 4'($urandom())};
				end else begin
					addr = {8'h00, 24'($urandom())};
				end
			end else if (kind < 78) begin
				if ($urandom_range(0, 1) == 0) begin
					addr = {8'hFE, 12'h000, 1'b1, 4'h0, 3'($urandom()), 4'($urandom())};
				end else begin
					addr = {8'hFE, 12'h000, 1'b1, 11'($urandom())};
				end
			end else if (kind < 90) begin
				addr = {8'hFE, 21'h0, 3'($urandom())};
			end else begin
				case ($urandom_range(0, 3))
					0: addr = $urandom_range(32'h0100_0000, 32'hFDFF_FFFF);
					1: addr = $urandom_range(32'hFF00_0000, 32'hFFFF_FFFF);
					2: addr = 32'hFE00_0000 | $urandom_range(32'h8, 32'h7FF);
					default: addr = 32'hFE00_0000 | $urandom_range(32'h1000, 32'hFF_FFFF);
				endcase
			end
			wr    = 1'($urandom_range(0, 1));
			len   = ($urandom_range(0, 99) < 15) ? $urandom_range(9, 12) : $urandom_range(1, 8);
			close = ($urandom_range(0, 9) != 0);
			for (int i = 0; i < len; i++) begin
				b = random_beat();
				if (i == 0) begin
					b.req_type = REQ_OPEN;
					b.address  = addr;
					b.is_write = wr;
				end
				b.last = close && (i == len - 1);
				send_beat(b);
			end
			bursts_sent++;
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		target = items_sent + count;
		while (items_sent < target) begin
			send_random_burst();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		mirror.set_reg(idx, val);
		@(posedge clk);
	endtask

	// drop valid, wait for every reply, then let the pipeline go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		while (mirror.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		mirror = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 18;
		recv_idle_pct = 45;

		// clock words at their reset values
		send_fields(REQ_OPEN, 32'hFE00_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
		// a write into clock space is dropped
		send_fields(REQ_OPEN, 32'hFE00_0006, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		// top of main memory; the second beat overruns the cell
		send_fields(REQ_OPEN, 32'h00FF_FFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0);
		send_fields(REQ_MORE, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_fields(REQ_OPEN, 32'h00FF_FFFE, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
		// one byte enable at a time, then neither
		send_fields(REQ_OPEN, 32'h0000_0000, 1'b1, 16'hA5A5, 1'b1, 1'b0, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'h5A5A, 1'b0, 1'b1, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b1);
		send_fields(REQ_OPEN, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
		// scratch store edges
		send_fields(REQ_OPEN, 32'hFE00_0FFE, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_fields(REQ_OPEN, 32'hFE00_0FFF, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0);
		send_fields(REQ_MORE, 32'h0000_0000, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_fields(REQ_OPEN, 32'hFE00_0800, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
		// unmapped space, inside and outside the IO page
		send_fields(REQ_OPEN, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_fields(REQ_OPEN, 32'h0100_0000, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_fields(REQ_OPEN, 32'hFE00_0008, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1);
		send_fields(REQ_OPEN, 32'hFE00_1000, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		// continuation with no open transaction
		send_fields(REQ_MORE, 32'h0000_0000, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);

		settle();
		write_reg(CFG_CPU_CLOCK, '1);
		write_reg(CFG_BUS_CLOCK, '0);
		write_reg(CFG_SPARE_2, 32'hDEAD_BEEF);
		write_reg(CFG_SPARE_3, '1);
		run_random(RANDOM_ITEMS / 3);

		settle();
		write_reg(CFG_CPU_CLOCK, '0);
		write_reg(CFG_BUS_CLOCK, '1);
		send_idle_pct = 45;
		recv_idle_pct = 18;
		run_random(RANDOM_ITEMS / 3);

		settle();
		write_reg(CFG_CPU_CLOCK, $urandom());
		write_reg(CFG_BUS_CLOCK, $urandom());
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// long output hold while the input keeps pushing
		hold_req = 1'b1;
		run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		settle();
		$display("%0d beats in %0d random bursts plus directed edges; replies by region:",
			items_sent, bursts_sent);
		$display("  main %0d, clock %0d, scratch %0d, unmapped %0d, past cell end %0d",
			mirror.region_hits[RGN_MAIN], mirror.region_hits[RGN_CLOCK],
			mirror.region_hits[RGN_SCRATCH], mirror.region_hits[RGN_UNMAPPED],
			mirror.past_hits);
		if (mirror.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
